/* hdl/assert_macros.svh */
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

/* hdl/cbpg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package cbpg_pkg;
   localparam int MAX_STEPS_DEF = 63;
   localparam int FRAC_BITS_DEF = 16;
   localparam int COORD_W = 15;
   localparam int STEP_W = 8;

   typedef struct packed {
      logic [COORD_W-1:0] p0_x;
      logic [COORD_W-1:0] p0_y;
      logic [COORD_W-1:0] p1_x;
      logic [COORD_W-1:0] p1_y;
      logic [COORD_W-1:0] p2_x;
      logic [COORD_W-1:0] p2_y;
      logic [COORD_W-1:0] p3_x;
      logic [COORD_W-1:0] p3_y;
      logic [STEP_W-1:0]  step_count;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] point_x;
      logic [COORD_W-1:0] point_y;
      logic               last;
   } rsp_type;
endpackage
`default_nettype wire

/* hdl/cubic_bezier_point_generator.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Cubic Bezier point generator. A request transfer carries four control
// points and a step count S (zero taken as one, above MAX_STEPS saturated);
// the block returns S+1 points for t = k/S, the last one flagged. A curve
// occupies the block until its final point is issued; a point takes six pipeline
// stages (t, squares, cubes, weights, products, sum) from issue to output.
// The next request is taken in the cycle after the sequencer has issued the
// final point of the current one; an output stall holds the issue of points.
module cubic_bezier_point_generator #(
   parameter int MAX_STEPS = cbpg_pkg::MAX_STEPS_DEF,
   parameter int FRAC_BITS = cbpg_pkg::FRAC_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire cbpg_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output cbpg_pkg::rsp_type     rsp_data
);
   import cbpg_pkg::*;

   localparam int KW = $clog2(MAX_STEPS + 1);
   localparam int F = FRAC_BITS;
   localparam int TW = F + 1;
   localparam int WW = F + 3;
   localparam int AW = WW + COORD_W + 2;
   localparam int NS = 6;

   // pipeline advance
   logic adv;
   logic [NS-1:0] v_ff;
   assign adv = !(rsp_valid && rsp_stall);

   // sequencer
   logic busy_ff;
   logic [KW-1:0] k_ff, s_ff;
   req_type cur_ff;
   logic [KW-1:0] s_sat;
   logic issue, fin;
   always_comb begin
      if (req_data.step_count == '0) s_sat = KW'(1);
      else if (req_data.step_count > STEP_W'(MAX_STEPS)) s_sat = KW'(MAX_STEPS);
      else s_sat = KW'(req_data.step_count);
   end
   assign issue = busy_ff && adv;
   assign fin = issue && (k_ff == s_ff);
   assign req_stall = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (req_valid && !busy_ff) begin
         busy_ff <= 1'b1;
      end else if (fin) begin
         busy_ff <= 1'b0;
      end
      if (req_valid && !busy_ff) begin
         cur_ff <= req_data;
         s_ff <= s_sat;
         k_ff <= '0;
      end else if (issue) begin
         k_ff <= k_ff + KW'(1);
      end
   end

   // t = floor(k*ONE/S) tracked per curve as quotient q and remainder r < S;
   // each point adds ONE/S as a quotient and remainder pair.
   logic [TW-1:0] q_ff;
   logic [F:0] r_ff;
   logic [TW-1:0] step_q_ff;
   logic [F:0] step_r_ff;
   logic [F+1:0] r_sum;
   always_comb r_sum = {1'b0, r_ff} + {1'b0, step_r_ff};
   // step quotient/remainder of ONE/S from a constant table
   logic [TW-1:0] dq;
   logic [F:0] dr;
   always_comb begin
      dq = '0;
      dr = '0;
      for (int i = 1; i <= MAX_STEPS; i++) begin
         if (s_sat == KW'(i)) begin
            dq = TW'((64'd1 << F) / 64'(i));
            dr = (F+1)'((64'd1 << F) % 64'(i));
         end
      end
   end
   always_ff @(posedge clock) begin
      if (req_valid && !busy_ff) begin
         q_ff <= '0;
         r_ff <= '0;
         step_q_ff <= dq;
         step_r_ff <= dr;
      end else if (issue) begin
         if (r_sum >= (F+2)'(s_ff)) begin
            q_ff <= q_ff + step_q_ff + TW'(1);
            r_ff <= (F+1)'(r_sum - (F+2)'(s_ff));
         end else begin
            q_ff <= q_ff + step_q_ff;
            r_ff <= r_sum[F:0];
         end
      end
   end

   // stage 1: t, u
   logic [TW-1:0] t1_ff, u1_ff;
   logic l1_ff;
   req_type c1_ff;
   // stage 2: squares
   logic [TW-1:0] t2_ff, u2_ff, ta_ff, ua_ff;
   logic l2_ff;
   req_type c2_ff;
   // stage 3: cubes and cross terms
   logic [TW-1:0] t3_ff, u3_ff, x1_ff, x2_ff;
   logic l3_ff;
   req_type c3_ff;
   // stage 4: weights
   logic [WW-1:0] w_ff [4];
   logic l4_ff;
   req_type c4_ff;
   // stage 5: products
   logic [AW-1:0] px_ff [4], py_ff [4];
   logic l5_ff;
   // stage 6: output
   rsp_type o_ff;

   logic [2*TW-1:0] m_tt, m_uu, m_t3, m_u3, m_x1, m_x2;
   always_comb begin
      m_tt = t1_ff * t1_ff;
      m_uu = u1_ff * u1_ff;
      m_t3 = t2_ff * ta_ff;
      m_u3 = u2_ff * ua_ff;
      m_x1 = u2_ff * ta_ff;
      m_x2 = ua_ff * t2_ff;
   end

   logic [AW-1:0] sx, sy;
   logic [AW-F-1:0] vx, vy;
   always_comb begin
      sx = px_ff[0] + px_ff[1] + px_ff[2] + px_ff[3];
      sy = py_ff[0] + py_ff[1] + py_ff[2] + py_ff[3];
      vx = sx[AW-1:F];
      vy = sy[AW-1:F];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[NS-2:0], busy_ff};
      end
      if (adv) begin
         t1_ff <= q_ff;
         u1_ff <= TW'(1 << F) - q_ff;
         l1_ff <= (k_ff == s_ff);
         c1_ff <= cur_ff;

         t2_ff <= TW'(m_tt >> F);
         u2_ff <= TW'(m_uu >> F);
         ta_ff <= t1_ff;
         ua_ff <= u1_ff;
         l2_ff <= l1_ff;
         c2_ff <= c1_ff;

         t3_ff <= TW'(m_t3 >> F);
         u3_ff <= TW'(m_u3 >> F);
         x1_ff <= TW'(m_x1 >> F);
         x2_ff <= TW'(m_x2 >> F);
         l3_ff <= l2_ff;
         c3_ff <= c2_ff;

         w_ff[0] <= WW'(u3_ff);
         w_ff[1] <= WW'(x1_ff) * WW'(3);
         w_ff[2] <= WW'(x2_ff) * WW'(3);
         w_ff[3] <= WW'(t3_ff);
         l4_ff <= l3_ff;
         c4_ff <= c3_ff;

         px_ff[0] <= AW'(w_ff[0]) * AW'(c4_ff.p0_x);
         px_ff[1] <= AW'(w_ff[1]) * AW'(c4_ff.p1_x);
         px_ff[2] <= AW'(w_ff[2]) * AW'(c4_ff.p2_x);
         px_ff[3] <= AW'(w_ff[3]) * AW'(c4_ff.p3_x);
         py_ff[0] <= AW'(w_ff[0]) * AW'(c4_ff.p0_y);
         py_ff[1] <= AW'(w_ff[1]) * AW'(c4_ff.p1_y);
         py_ff[2] <= AW'(w_ff[2]) * AW'(c4_ff.p2_y);
         py_ff[3] <= AW'(w_ff[3]) * AW'(c4_ff.p3_y);
         l5_ff <= l4_ff;

         o_ff.point_x <= (vx > (AW-F)'(2**COORD_W - 1)) ? '1 : COORD_W'(vx);
         o_ff.point_y <= (vy > (AW-F)'(2**COORD_W - 1)) ? '1 : COORD_W'(vy);
         o_ff.last <= l5_ff;
      end
   end

   assign rsp_valid = v_ff[NS-1];
   assign rsp_data = o_ff;

   `ASSERT_CLK(a_k_bound, clock, reset, busy_ff |-> (k_ff <= s_ff))
   `ASSERT_CLK(a_fin_idle, clock, reset, fin |=> !busy_ff)
   `ASSERT_CLK(a_hold, clock, reset, (rsp_valid && rsp_stall) |=> $stable(v_ff))
endmodule
`default_nettype wire
